FILE: design/lz_pkg.sv
// ----------------------------------------------------------------------------
// lz_pkg : shared types and constants for the LZ77 token decoder
// Transaction structs, front-to-back command format, state encodings.
// ----------------------------------------------------------------------------
package lz_pkg;

  localparam int WIN_BYTES  = 4096;
  localparam int WIN_AW     = 12;
  localparam int CNT_W      = 13;   // decoded count, saturates at WIN_BYTES
  localparam int LEN_W      = 4;
  localparam int MAX_MATCH  = 15;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = 1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       error_flag;
    logic       done_res;
  } out_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LIT_NEXT,
    PH_OFF_LO,
    PH_MATCH_NEXT
  } phase_t;

  typedef enum logic [1:0] {
    CMD_BYTE,   // emit and record one literal byte
    CMD_COPY,   // copy length bytes from offset back
    CMD_MARK    // one result without a byte
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [WIN_AW-1:0] offset;
    logic [LEN_W-1:0]  length;
    logic              err;
    logic              done;   // end of stream: rewind write pointer after
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE
  } bk_state_t;

endpackage

FILE: design/lz_ram.sv
// ----------------------------------------------------------------------------
// lz_ram : generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lz_front.sv
// ----------------------------------------------------------------------------
// lz_front : token parser
// Accepts stream bytes, tracks token phase and errors, issues commands.
// ----------------------------------------------------------------------------
module lz_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         acc,
  input  lz_pkg::in_t  in_data,
  output logic         cmd_push,
  output lz_pkg::cmd_t cmd
);
  import lz_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [3:0]        off_hi_r, off_hi_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              err_r, err_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [WIN_AW-1:0] off;
  logic [CNT_W-1:0]  cnt_sum;
  logic [CNT_W-1:0]  cnt_inc;
  logic              bad_off;

  assign off     = {off_hi_r, in_data.in_byte};
  assign cnt_sum = cnt_r + CNT_W'(len_r);
  assign cnt_inc = cnt_r + CNT_W'(1);
  assign bad_off = (off == '0) || (CNT_W'(off) > cnt_r) || (32'(len_r) > MAX_MATCH);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (in_data.stream_end) begin
        phase_nxt = PH_FIRST;
      end else if (!err_r) begin
        case (phase_r)
          PH_FIRST: begin
            phase_nxt = (in_data.in_byte[7:4] == '0) ? PH_LIT_NEXT : PH_OFF_LO;
          end
          PH_LIT_NEXT, PH_MATCH_NEXT: begin
            phase_nxt = PH_FIRST;
          end
          PH_OFF_LO: begin
            if (!bad_off) begin
              phase_nxt = PH_MATCH_NEXT;
            end
          end
          default: begin
            phase_nxt = PH_FIRST;
          end
        endcase
      end
    end
  end

  // token fields, counters and commands
  always_comb begin
    len_nxt    = len_r;
    off_hi_nxt = off_hi_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    err_nxt    = err_r;
    cnt_nxt    = cnt_r;
    cmd_push   = 1'b0;
    cmd        = '0;
    cmd.kind   = CMD_MARK;

    if (acc) begin
      if (in_data.stream_end) begin
        cmd_push = 1'b1;
        cmd.done = 1'b1;
        cmd.err  = err_r;
        if (!err_r) begin
          if (phase_r != PH_FIRST) begin
            cmd.err = 1'b1;   // truncated token
          end else if (in_data.in_byte == 8'h00 && pend_v_r) begin
            cmd.kind = CMD_BYTE;
            cmd.data = pend_r;
          end
        end
        // new stream starts from scratch
        len_nxt    = '0;
        off_hi_nxt = '0;
        pend_nxt   = '0;
        pend_v_nxt = 1'b0;
        err_nxt    = 1'b0;
        cnt_nxt    = '0;
      end else if (!err_r) begin
        case (phase_r)
          PH_FIRST: begin
            if (pend_v_r) begin
              cmd_push   = 1'b1;
              cmd.kind   = CMD_BYTE;
              cmd.data   = pend_r;
              pend_v_nxt = 1'b0;
              if (cnt_r < CNT_W'(WIN_BYTES)) begin
                cnt_nxt = cnt_inc;
              end
            end
            len_nxt    = in_data.in_byte[7:4];
            off_hi_nxt = in_data.in_byte[3:0];
          end
          PH_LIT_NEXT, PH_MATCH_NEXT: begin
            pend_nxt   = in_data.in_byte;
            pend_v_nxt = 1'b1;
          end
          PH_OFF_LO: begin
            cmd_push = 1'b1;
            if (bad_off) begin
              cmd.kind   = CMD_MARK;
              cmd.err    = 1'b1;
              err_nxt    = 1'b1;
              pend_v_nxt = 1'b0;
            end else begin
              cmd.kind   = CMD_COPY;
              cmd.offset = off;
              cmd.length = len_r;
              cnt_nxt    = (cnt_sum > CNT_W'(WIN_BYTES)) ? CNT_W'(WIN_BYTES) : cnt_sum;
            end
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      len_r    <= '0;
      off_hi_r <= '0;
      pend_r   <= '0;
      pend_v_r <= 1'b0;
      err_r    <= 1'b0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      off_hi_r <= off_hi_nxt;
      pend_r   <= pend_nxt;
      pend_v_r <= pend_v_nxt;
      err_r    <= err_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: design/lz_cmdq.sv
// ----------------------------------------------------------------------------
// lz_cmdq : command queue between parser and executor
// Small register FIFO; head is presented combinationally.
// ----------------------------------------------------------------------------
module lz_cmdq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lz_pkg::cmd_t wr_cmd,
  output logic         q_full,
  input  logic         pop,
  output logic         q_valid,
  output lz_pkg::cmd_t rd_cmd
);
  import lz_pkg::*;

  cmd_t               ent_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_cmd  = ent_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/lz_back.sv
// ----------------------------------------------------------------------------
// lz_back : command executor
// Writes decoded bytes to history, runs match copies, buffers results.
// ----------------------------------------------------------------------------
module lz_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmd_valid,
  input  lz_pkg::cmd_t cmd,
  output logic         cmd_pop,
  input  logic         res_pop,
  output logic         res_empty,
  output lz_pkg::out_t res
);
  import lz_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [WIN_AW-1:0] wp_r, wp_nxt;
  logic [WIN_AW-1:0] off_r;
  logic [LEN_W-1:0]  rem_r, rem_nxt;

  // history RAM
  logic              ram_we, ram_re;
  logic [WIN_AW-1:0] ram_raddr;
  logic [7:0]        ram_wdata, ram_q;

  // result buffer
  out_t               oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_AW:0]   oq_cnt_r;
  logic               space, res_push, res_take;
  out_t               res_d;
  logic               load_copy;

  assign space     = (oq_cnt_r != (OUTQ_AW+1)'(OUTQ_DEPTH));
  assign res_empty = (oq_cnt_r == '0);
  assign res       = oq_r[oq_rd_r];
  assign res_take  = res_pop && !res_empty;
  assign ram_raddr = wp_r - off_r;

  lz_ram #(
    .WIDTH (8),
    .DEPTH (WIN_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_COPY) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        if (space) begin
          state_nxt = (rem_r == LEN_W'(1)) ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = cmd.data;
    wp_nxt    = wp_r;
    rem_nxt   = rem_r;
    load_copy = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_BYTE: begin
              if (space) begin
                cmd_pop          = 1'b1;
                res_push         = 1'b1;
                res_d.out_byte   = cmd.data;
                res_d.byte_valid = 1'b1;
                res_d.run_last   = 1'b1;
                res_d.error_flag = cmd.err;
                res_d.done_res   = cmd.done;
                ram_we           = 1'b1;
                wp_nxt           = cmd.done ? '0 : wp_r + 1'b1;
              end
            end
            CMD_MARK: begin
              if (space) begin
                cmd_pop          = 1'b1;
                res_push         = 1'b1;
                res_d.run_last   = 1'b1;
                res_d.error_flag = cmd.err;
                res_d.done_res   = cmd.done;
                if (cmd.done) begin
                  wp_nxt = '0;
                end
              end
            end
            CMD_COPY: begin
              cmd_pop   = 1'b1;
              load_copy = 1'b1;
              rem_nxt   = cmd.length;
            end
            default: begin
              cmd_pop = 1'b1;   // unused code, drop it
            end
          endcase
        end
      end
      BK_READ: begin
        ram_re = 1'b1;
      end
      BK_WRITE: begin
        if (space) begin
          res_push         = 1'b1;
          res_d.out_byte   = ram_q;
          res_d.byte_valid = 1'b1;
          res_d.run_last   = (rem_r == LEN_W'(1));
          ram_we           = 1'b1;
          ram_wdata        = ram_q;
          wp_nxt           = wp_r + 1'b1;
          rem_nxt          = rem_r - 1'b1;
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_copy) begin
      off_r <= cmd.offset;
    end
    if (res_push) begin
      oq_r[oq_wr_r] <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      wp_r     <= '0;
      rem_r    <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rem_r   <= rem_nxt;
      if (res_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (res_take) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      if (res_push && !res_take) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (res_take && !res_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/lz77_token_decoder_top.sv
// ----------------------------------------------------------------------------
// lz77_token_decoder_top : streaming LZ77 token decoder
// Parser front end, command queue, history-based copy engine with result
// buffer.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload  | transaction
//  ---------+------------------------+----------+-----------------------------
//  input    | push in / full out     | in_data  | one compressed byte (+end)
//  result   | pop in / empty out     | out_data | one decoded byte or marker
//
//  Flow: a byte that gives no result occupies only the parser; a literal or
//    marker result also passes through the executor. A match copy is first
//    dispatched, then each copied byte takes a registered history read, then
//    write back and emit, so a three-byte match token holds the executor for
//    up to 15 copied bytes.
//  Reset: rst_n synchronous, active low; clears parser, queues and write
//    pointer. History is not cleared: an entry is read only after written.
//  Stalls: pop held low fills the 2-entry result buffer and halts the copy
//    engine; the 4-entry command queue then fills and full rises.
//
module lz77_token_decoder_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  lz_pkg::in_t  in_data,
  output logic         empty,
  input  logic         pop,
  output lz_pkg::out_t out_data
);
  import lz_pkg::*;

  logic acc;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;

  // parser accepts only while the queue has room for a command
  assign full = cmd_full;
  assign acc  = push && !cmd_full;

  lz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  lz_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_cmd  (cmd_in),
    .q_full  (cmd_full),
    .pop     (cmd_pop),
    .q_valid (cmd_valid),
    .rd_cmd  (cmd_head)
  );

  lz_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (out_data)
  );

  // a command is never produced into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // the executor only takes commands that are present
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // end-of-stream and marker results always close their transaction group
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.done_res || !out_data.byte_valid)) |-> out_data.run_last)
    else $error("done or marker result without run_last");

  // reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results present after reset");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for lz77_token_decoder_top
// Feeds compressed token streams through the push/full port, drains decoded
// bytes through pop/empty and checks each one against a local decoder model.
// ----------------------------------------------------------------------------
module testbench;
  import lz_pkg::*;

  // Pre-computed results for the directed rows: {byte, valid, last, err, done}
  localparam out_t RES_NONE      = '0;
  localparam out_t RES_EMPTY_END = {8'h00, 4'b0101};
  localparam out_t RES_BAD_OFF   = {8'h00, 4'b0110};
  localparam out_t RES_ERR_END   = {8'h00, 4'b0111};

  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 64;     // outlasts the longest match copy
  localparam int RANDOM_ITEMS   = 420;
  localparam int MAX_PRINTS     = 20;

  typedef enum int {
    SK_CLEAN,        // well-formed tokens, valid offsets
    SK_BAD_OFFSET,   // zero or out-of-range offset, then ignored bytes
    SK_TRUNCATED,    // flag byte arrives mid-token
    SK_NOISE         // random bytes
  } stream_kind_t;

  typedef struct {
    in_t  item;
    bit   fixed;     // expectation typed in below instead of predicted
    out_t fixed_res;
  } stim_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_t  in_data;
  logic empty;
  logic pop;
  out_t out_data;

  lz77_token_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Clock, reset, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Worst case, every item giving 15 results each behind the longest pop wait,
  // still ends well before the 10 ms limit.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Decoder model: own copy of history, pointers and parser state
  // --------------------------------------------------------------------------
  logic [7:0]        hist [0:WIN_BYTES-1];
  logic [WIN_AW-1:0] wr_ptr;
  logic [CNT_W-1:0]  dec_cnt;
  phase_t            phase;
  logic [LEN_W-1:0]  tok_len;
  logic [WIN_AW-1:0] tok_off;
  logic [7:0]        held_byte;
  logic              held_vld;
  logic              err_st;

  out_t decoded_q [$];     // predicted results not yet popped
  out_t step_out  [$];     // results of the transaction being predicted

  int n_mismatch  = 0;
  int n_checked   = 0;
  int n_err_res   = 0;
  int n_accepted  = 0;
  int n_streams   = 0;

  function automatic void clear_stream();
    wr_ptr    = '0;
    dec_cnt   = '0;
    phase     = PH_FIRST;
    tok_len   = '0;
    tok_off   = '0;
    held_byte = '0;
    held_vld  = 1'b0;
    err_st    = 1'b0;
  endfunction

  function automatic void record_byte(logic [7:0] b);
    hist[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;          // 12-bit pointer wraps with the window
    if (dec_cnt < WIN_BYTES)
      dec_cnt = dec_cnt + 1'b1;
  endfunction

  function automatic void emit_results(logic [7:0] bytes [$], bit force_one, bit done);
    int   cnt;
    out_t r;
    cnt = bytes.size();
    if (cnt == 0 && force_one)
      cnt = 1;
    for (int k = 0; k < cnt; k++) begin
      r.byte_valid = (k < bytes.size());
      r.out_byte   = r.byte_valid ? bytes[k] : 8'h00;
      r.run_last   = (k == cnt - 1);
      r.error_flag = err_st;
      r.done_res   = done;
      step_out     = {step_out, r};
    end
  endfunction

  // Decode one compressed byte; results land in step_out
  function automatic void decode_step(in_t it);
    logic [7:0]        bytes [$];
    logic [WIN_AW-1:0] off;
    logic [WIN_AW-1:0] idx;
    logic [7:0]        b;
    step_out.delete();

    if (it.stream_end) begin
      if (!err_st) begin
        if (phase != PH_FIRST)
          err_st = 1'b1;                      // truncated token
        else if (it.in_byte == 8'h00 && held_vld) begin
          record_byte(held_byte);
          bytes = {bytes, held_byte};
        end
      end
      emit_results(bytes, 1'b1, 1'b1);
      clear_stream();
      return;
    end

    if (err_st)
      return;                                 // sticky error swallows bytes

    case (phase)
      PH_FIRST: begin
        if (held_vld) begin
          record_byte(held_byte);
          bytes    = {bytes, held_byte};
          held_vld = 1'b0;
        end
        tok_len = it.in_byte[7:4];
        if (tok_len == 0) begin
          tok_off = '0;
          phase   = PH_LIT_NEXT;
        end else begin
          tok_off = {it.in_byte[3:0], 8'h00};
          phase   = PH_OFF_LO;
        end
      end
      PH_LIT_NEXT, PH_MATCH_NEXT: begin
        held_byte = it.in_byte;
        held_vld  = 1'b1;
        phase     = PH_FIRST;
      end
      default: begin
        off     = tok_off | {4'h0, it.in_byte};
        tok_off = off;
        if (off == 0 || off > dec_cnt || tok_len > MAX_MATCH) begin
          err_st   = 1'b1;
          held_vld = 1'b0;
          emit_results(bytes, 1'b1, 1'b0);
          return;
        end
        // byte-by-byte so overlapping copies repeat themselves
        for (int k = 0; k < tok_len; k++) begin
          idx   = wr_ptr - off;
          b     = hist[idx];
          record_byte(b);
          bytes = {bytes, b};
        end
        phase = PH_MATCH_NEXT;
      end
    endcase
    emit_results(bytes, 1'b0, 1'b0);
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (n_mismatch < MAX_PRINTS)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_mismatch++;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = decoded_q.pop_front();
    n_checked++;
    if (got.error_flag)
      n_err_res++;
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("result %0d out_byte %h, want %h",
                                n_checked, got.out_byte, want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                n_checked, got.byte_valid, want.byte_valid));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("result %0d run_last %b, want %b",
                                n_checked, got.run_last, want.run_last));
    if (got.error_flag !== want.error_flag)
      report_mismatch($sformatf("result %0d error_flag %b, want %b",
                                n_checked, got.error_flag, want.error_flag));
    if (got.done_res !== want.done_res)
      report_mismatch($sformatf("result %0d done_res %b, want %b",
                                n_checked, got.done_res, want.done_res));
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the DUT's own
  // nonblocking updates land, so handshake values are the pre-edge ones.
  // --------------------------------------------------------------------------
  logic cur_fixed;
  out_t cur_fixed_res;

  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      n_accepted++;
      decode_step(in_data);
      if (cur_fixed)
        decoded_q = {decoded_q, cur_fixed_res};   // typed-in row overrides model
      else
        decoded_q = {decoded_q, step_out};
    end
    if (rst_n && pop && !empty)
      check_result(out_data);
  end

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  stim_t stim_q [$];
  int    tx_gap_max;
  bit    rx_burst;
  bit    rx_hold_req;

  task automatic add_row(logic [7:0] b, logic e, bit fixed, out_t res);
    stim_t s;
    s.item.in_byte    = b;
    s.item.stream_end = e;
    s.fixed           = fixed;
    s.fixed_res       = res;
    stim_q            = {stim_q, s};
  endtask

  task automatic add_byte(logic [7:0] b);
    add_row(b, 1'b0, 1'b0, RES_NONE);
  endtask

  // Mostly a zero flag (held byte kept), sometimes any other value
  task automatic add_flag();
    if ($urandom_range(0, 3) != 0)
      add_row(8'h00, 1'b1, 1'b0, RES_NONE);
    else
      add_row(8'($urandom_range(1, 255)), 1'b1, 1'b0, RES_NONE);
  endtask

  // Builds one stream; cnt tracks decoded bytes the same way the parser does
  task automatic gen_stream(stream_kind_t kind, int n_tok);
    int          cnt;
    int          bad_at;
    int          len;
    int          hi;
    logic [11:0] off;
    cnt    = 0;
    bad_at = (kind == SK_BAD_OFFSET) ? $urandom_range(0, n_tok) : -1;

    if (kind == SK_NOISE) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      add_row(8'($urandom_range(0, 255)), 1'b1, 1'b0, RES_NONE);
      return;
    end

    for (int t = 0; t <= n_tok; t++) begin
      if (t > 0)
        cnt = (cnt < WIN_BYTES) ? cnt + 1 : cnt;   // held byte lands now
      if (t == bad_at) begin
        len = $urandom_range(1, 15);
        if (cnt >= WIN_BYTES - 1 || $urandom_range(0, 1) == 0)
          off = '0;
        else
          off = 12'($urandom_range(cnt + 1, WIN_BYTES - 1));
        add_byte({len[3:0], off[11:8]});
        add_byte(off[7:0]);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        break;
      end
      if (t == n_tok)
        break;
      if (cnt > 0 && $urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, 15);
        hi  = (cnt > WIN_BYTES - 1) ? WIN_BYTES - 1 : cnt;
        // short offsets give overlapping copies, long ones reach far back
        if ($urandom_range(0, 1) == 0 && hi > 16)
          hi = 16;
        off = 12'($urandom_range(1, hi));
        add_byte({len[3:0], off[11:8]});
        add_byte(off[7:0]);
        add_byte(8'($urandom_range(0, 255)));
        cnt = (cnt + len > WIN_BYTES) ? WIN_BYTES : cnt + len;
      end else begin
        // the low nibble of a literal's first byte is don't-care
        add_byte({4'h0, 4'($urandom_range(0, 15))});
        add_byte(8'($urandom_range(0, 255)));
      end
    end

    if (kind == SK_TRUNCATED) begin
      if ($urandom_range(0, 1) == 0)
        add_byte({4'h0, 4'($urandom_range(0, 15))});
      else begin
        add_byte({4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))});
        if ($urandom_range(0, 1) == 0)
          add_byte(8'($urandom_range(0, 255)));
      end
    end
    add_flag();
  endtask

  // --------------------------------------------------------------------------
  // Sender: one transaction per queued item, with a random gap in front.
  // push is left high across back-to-back transactions.
  // --------------------------------------------------------------------------
  task automatic send_all();
    stim_t s;
    int    gap;
    while (stim_q.size() > 0) begin
      s   = stim_q.pop_front();
      gap = $urandom_range(0, tx_gap_max);
      repeat (gap) begin
        @(negedge clk);
        push = 1'b0;
      end
      @(negedge clk);
      in_data       = s.item;
      cur_fixed     = s.fixed;
      cur_fixed_res = s.fixed_res;
      push          = 1'b1;
      @(posedge clk);
      while (full) @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random pop gaps; one long hold-off on request so the result
  // buffer and command queue fill and full backs up into the sender.
  // --------------------------------------------------------------------------
  initial begin
    int wait_n;
    int n_pops;
    n_pops = 0;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        @(negedge clk);
        pop = 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      if (n_pops % 40 == 0)
        rx_burst = ($urandom_range(0, 3) == 0);
      wait_n = rx_burst ? 0 : $urandom_range(0, 16);
      repeat (wait_n) begin
        @(negedge clk);
        pop = 1'b0;
      end
      @(negedge clk);
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      n_pops++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stream_kind_t kind;
    int           sel;
    int           rand_start;
    push          = 1'b0;
    pop           = 1'b0;
    in_data       = '0;
    cur_fixed     = 1'b0;
    cur_fixed_res = RES_NONE;
    rx_burst      = 1'b0;
    rx_hold_req   = 1'b0;
    tx_gap_max    = 16;
    rst_n         = 1'b0;
    clear_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part.
    // Empty stream: flag byte alone gives a bare done marker.
    add_row(8'h00, 1'b1, 1'b1, RES_EMPTY_END);
    // Literals, overlapping copy of length 3, max-length copy, held byte
    // released by a zero flag.
    add_byte(8'h00); add_byte(8'hFF);
    add_byte(8'h00); add_byte(8'h41);
    add_byte(8'h30); add_byte(8'h01); add_byte(8'h80);
    add_byte(8'hF0); add_byte(8'h02); add_byte(8'h7E);
    add_row(8'h00, 1'b1, 1'b0, RES_NONE);
    // Zero offset: error marker, then a swallowed byte, then error at end.
    add_byte(8'h00); add_byte(8'h12);
    add_byte(8'h10);
    add_row(8'h00, 1'b0, 1'b1, RES_BAD_OFF);
    add_byte(8'h55);
    add_row(8'h00, 1'b1, 1'b1, RES_ERR_END);
    // Offset 4095 with nothing decoded yet.
    add_byte(8'h1F);
    add_row(8'hFF, 1'b0, 1'b1, RES_BAD_OFF);
    add_row(8'h01, 1'b1, 1'b1, RES_ERR_END);
    // Token cut short by the flag byte.
    add_byte(8'h00);
    add_row(8'h00, 1'b1, 1'b1, RES_ERR_END);
    // Nonzero flag drops the held byte.
    add_byte(8'h00); add_byte(8'hAA);
    add_row(8'hFF, 1'b1, 1'b1, RES_EMPTY_END);
    n_streams += 6;
    send_all();
    @(negedge clk);
    push = 1'b0;

    // Sender stands still until every result of the directed part is out.
    wait (decoded_q.size() == 0);

    // Random part. First a long clean stream at full input rate while the
    // receiver holds off.
    rand_start  = n_accepted;
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    gen_stream(SK_CLEAN, 40);
    send_all();
    n_streams++;

    while (n_accepted - rand_start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 14)      kind = SK_CLEAN;
      else if (sel < 16) kind = SK_BAD_OFFSET;
      else if (sel < 18) kind = SK_TRUNCATED;
      else               kind = SK_NOISE;
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      gen_stream(kind, $urandom_range(0, 20));
      send_all();
      n_streams++;
    end
    @(negedge clk);
    push = 1'b0;

    // Drain, then give the copy engine time to show any stray result.
    wait (decoded_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                decoded_q.size()));

    $display("Decoded %0d compressed bytes in %0d streams (clean, bad offset,",
             n_accepted, n_streams);
    $display("truncated, noise); %0d results checked, %0d carrying the error flag.",
             n_checked, n_err_res);
    if (n_mismatch == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
